// ===== rtl/core/dvdd_pkg.sv =====
`timescale 1ns / 1ps

package dvdd_pkg;

  // Status codes for one date.
  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_YEAR = 2'd1,
    ST_MON  = 2'd2,
    ST_DAY  = 2'd3
  } status_e;

  // Register indexes, decoded from paddr[2].
  localparam logic REG_YEAR_FLOOR   = 1'b0;
  localparam logic REG_CURRENT_YEAR = 1'b1;

  localparam int unsigned RD_W   = 25;

  typedef struct packed {
    logic [13:0] year_a;
    logic [3:0]  month_a;
    logic [4:0]  day_a;
    logic [13:0] year_b;
    logic [3:0]  month_b;
    logic [4:0]  day_b;
  } req_t;

  typedef struct packed {
    status_e            status_a;
    status_e            status_b;
    logic signed [23:0] day_difference;
  } rsp_t;

  typedef struct packed {
    logic [13:0] year_floor;
    logic [13:0] current_year;
  } cfg_t;

  // Days in a month of a common year; zero for codes that are no month.
  function automatic logic [4:0] month_len(input logic [3:0] m);
    logic [4:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  // (153*tm - 457)/5 for the March-based month tm that month code m maps to.
  function automatic logic [8:0] month_offset(input logic [3:0] m);
    logic [8:0] off;
    case (m)
      4'd0:    off = 9'd275;
      4'd1:    off = 9'd306;
      4'd2:    off = 9'd337;
      4'd3:    off = 9'd0;
      4'd4:    off = 9'd31;
      4'd5:    off = 9'd61;
      4'd6:    off = 9'd92;
      4'd7:    off = 9'd122;
      4'd8:    off = 9'd153;
      4'd9:    off = 9'd184;
      4'd10:   off = 9'd214;
      4'd11:   off = 9'd245;
      4'd12:   off = 9'd275;
      4'd13:   off = 9'd306;
      4'd14:   off = 9'd337;
      default: off = 9'd367;
    endcase
    return off;
  endfunction

endpackage

// ===== rtl/core/dvdd_date_unit.sv =====
`timescale 1ns / 1ps

module dvdd_date_unit (
  input  logic                          clk_i,
  input  dvdd_pkg::cfg_t                cfg_i,
  input  logic [13:0]                   year_i,
  input  logic [3:0]                    month_i,
  input  logic [4:0]                    day_i,
  output dvdd_pkg::status_e             status_o,
  output logic [dvdd_pkg::RD_W-1:0]     rd_o
);

  // Stage 1: range checks, March shift, reciprocal divisions by 100 and 400.
  logic        year_bad_d, year_bad_q;
  logic        month_bad_d, month_bad_q;
  logic        is_feb_d, is_feb_q;
  logic        mod4z_d, mod4z_q;
  logic [4:0]  len_base_d, len_base_q;
  logic [4:0]  day_d, day_q;
  logic [13:0] year_d, year_q;
  logic [7:0]  qy100_d, qy100_q;
  logic        neg_d, neg_q;
  logic [13:0] tyu_d, tyu_q;
  logic [7:0]  qt100_d, qt100_q;
  logic [5:0]  qt400_d, qt400_q;
  logic [8:0]  moff_d, moff_q;
  logic [26:0] prod_y100, prod_t100;
  logic [24:0] prod_t400;
  logic        shift;

  always_comb begin
    shift       = (month_i < 4'd3);
    year_bad_d  = (year_i < cfg_i.year_floor) ||
                  ({1'b0, year_i} > ({1'b0, cfg_i.current_year} + 15'd1));
    month_bad_d = !(month_i inside {[4'd1:4'd12]});
    is_feb_d    = (month_i == 4'd2);
    mod4z_d     = (year_i[1:0] == 2'd0);
    len_base_d  = dvdd_pkg::month_len(month_i);
    day_d       = day_i;
    year_d      = year_i;
    // x*5243 >> 19 equals x/100 for every 14-bit x.
    prod_y100   = 27'(year_i) * 27'd5243;
    qy100_d     = prod_y100[26:19];
    neg_d       = shift && (year_i == 14'd0);
    if (neg_d) begin
      tyu_d = 14'd0;
    end else if (shift) begin
      tyu_d = year_i - 14'd1;
    end else begin
      tyu_d = year_i;
    end
    prod_t100   = 27'(tyu_d) * 27'd5243;
    qt100_d     = prod_t100[26:19];
    prod_t400   = 25'(tyu_d[13:2]) * 25'd5243;
    qt400_d     = prod_t400[24:19];
    moff_d      = dvdd_pkg::month_offset(month_i);
  end

  always_ff @(posedge clk_i) begin
    year_bad_q  <= year_bad_d;
    month_bad_q <= month_bad_d;
    is_feb_q    <= is_feb_d;
    mod4z_q     <= mod4z_d;
    len_base_q  <= len_base_d;
    day_q       <= day_d;
    year_q      <= year_d;
    qy100_q     <= qy100_d;
    neg_q       <= neg_d;
    tyu_q       <= tyu_d;
    qt100_q     <= qt100_d;
    qt400_q     <= qt400_d;
    moff_q      <= moff_d;
  end

  // Stage 2: leap rule and day check; the 365*ty product and the small terms.
  logic              r100z, leap;
  logic [4:0]        len;
  dvdd_pkg::status_e status2_d, status2_q;
  logic [24:0]       p365_d, p365_q;
  logic [24:0]       s_d, s_q;

  always_comb begin
    r100z = (year_q == 14'(14'(qy100_q) * 14'd100));
    leap  = (mod4z_q && !r100z) || (r100z && (qy100_q[1:0] == 2'd0));
    len   = len_base_q + 5'(is_feb_q && leap);
    if (year_bad_q) begin
      status2_d = dvdd_pkg::ST_YEAR;
    end else if (month_bad_q) begin
      status2_d = dvdd_pkg::ST_MON;
    end else if ((day_q == 5'd0) || (day_q > len)) begin
      status2_d = dvdd_pkg::ST_DAY;
    end else begin
      status2_d = dvdd_pkg::ST_OK;
    end
    // Year -1 contributes -365 and every quotient truncates to zero.
    p365_d = neg_q ? (25'd0 - 25'd365) : (25'(tyu_q) * 25'd365);
    s_d    = 25'(tyu_q[13:2]) - 25'(qt100_q) + 25'(qt400_q) + 25'(moff_q)
             + 25'(day_q) - 25'd306;
  end

  always_ff @(posedge clk_i) begin
    status2_q <= status2_d;
    p365_q    <= p365_d;
    s_q       <= s_d;
  end

  // Stage 3: final sum.
  dvdd_pkg::status_e status3_q;
  logic [24:0]       rd_q;

  always_ff @(posedge clk_i) begin
    status3_q <= status2_q;
    rd_q      <= p365_q + s_q;
  end

  assign status_o = status3_q;
  assign rd_o     = rd_q;

endmodule

// ===== rtl/core/date_validate_day_difference.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake                      Payload
// request   in         start && !busy                 req_i  (dvdd_pkg::req_t)
// result    out        done_o, one cycle, no stall    rsp_o  (dvdd_pkg::rsp_t)
// config    in         psel && penable && pwrite      paddr, pwdata (APB, pready high)
//
// A request is taken in every cycle; busy is never raised.
// Each result passes through three stages per date (checks and reciprocal
// divisions, leap rule and the 365-day product, final sum) and one stage for
// the difference of the two day numbers.
// Reset clears the valid bits and restores year floor 1500 and current_year 2021.
// The receiver cannot stall, so the pipeline never holds.
module date_validate_day_difference (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  dvdd_pkg::req_t req_i,
  output logic           done_o,
  output dvdd_pkg::rsp_t rsp_o,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [2:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);

  // Configuration registers. Only paddr[2] selects the register.
  dvdd_pkg::cfg_t cfg_q;
  logic           cfg_wr;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.year_floor   <= 14'd1500;
      cfg_q.current_year <= 14'd2021;
    end else if (cfg_wr) begin
      case (paddr[2])
        dvdd_pkg::REG_YEAR_FLOOR:   cfg_q.year_floor   <= pwdata[13:0];
        dvdd_pkg::REG_CURRENT_YEAR: cfg_q.current_year <= pwdata[13:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      dvdd_pkg::REG_YEAR_FLOOR:   prdata = 32'(cfg_q.year_floor);
      dvdd_pkg::REG_CURRENT_YEAR: prdata = 32'(cfg_q.current_year);
      default:                    prdata = 32'd0;
    endcase
  end

  // Valid bits travel beside the three stages of the date units.
  logic       accept;
  logic [2:0] valid_q;

  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 3'd0;
    end else begin
      valid_q <= {valid_q[1:0], accept};
    end
  end

  // One converter for each date of the request.
  dvdd_pkg::status_e           status_a, status_b;
  logic [dvdd_pkg::RD_W-1:0]   rd_a, rd_b;

  dvdd_date_unit u_date_a (
    .clk_i    (clk_i),
    .cfg_i    (cfg_q),
    .year_i   (req_i.year_a),
    .month_i  (req_i.month_a),
    .day_i    (req_i.day_a),
    .status_o (status_a),
    .rd_o     (rd_a)
  );

  dvdd_date_unit u_date_b (
    .clk_i    (clk_i),
    .cfg_i    (cfg_q),
    .year_i   (req_i.year_b),
    .month_i  (req_i.month_b),
    .day_i    (req_i.day_b),
    .status_o (status_b),
    .rd_o     (rd_b)
  );

  // Output stage. The true difference always fits in 24 bits, so the low
  // bits of the 25-bit modular difference are exact.
  logic                      done_q;
  dvdd_pkg::rsp_t            rsp_d, rsp_q;
  logic [dvdd_pkg::RD_W-1:0] diff;

  always_comb begin
    diff                 = rd_a - rd_b;
    rsp_d.status_a       = status_a;
    rsp_d.status_b       = status_b;
    rsp_d.day_difference = diff[23:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= valid_q[2];
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  // A result comes only from a request that start presented earlier.
  a_done_has_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start, 4))
    else $error("result without a matching request");

  // A good first date had a month in range and a nonzero day.
  a_ok_a_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (rsp_o.status_a == dvdd_pkg::ST_OK)) |->
      (($past(req_i.month_a, 4) != 4'd0) && ($past(req_i.month_a, 4) <= 4'd12) &&
       ($past(req_i.day_a, 4) != 5'd0)))
    else $error("first date reported good with bad month or day");

  a_ok_b_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (rsp_o.status_b == dvdd_pkg::ST_OK)) |->
      (($past(req_i.month_b, 4) != 4'd0) && ($past(req_i.month_b, 4) <= 4'd12) &&
       ($past(req_i.day_b, 4) != 5'd0)))
    else $error("second date reported good with bad month or day");

  // A day error on the first date is reported only when its month is in range.
  a_day_err_month: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (rsp_o.status_a == dvdd_pkg::ST_DAY)) |->
      (($past(req_i.month_a, 4) != 4'd0) && ($past(req_i.month_a, 4) <= 4'd12)))
    else $error("day error reported for an invalid month");

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;

  // Generous cycle budget, well above what 1400 requests at the worst sender
  // gap need. Drains, register traffic and reset add only a little to that.
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned ITEMS_PER_PHASE = 200;
  localparam int unsigned NUM_PHASES = 7;
  // Settle time after the last result before the window registers are touched.
  localparam int unsigned QUIET_CYCLES = 8;

  // Calendar model of the block. It holds the year window and the queue of
  // results still owed by the pipeline.
  class day_diff_ledger;
    int unsigned    min_yr;
    int unsigned    cur_yr;
    dvdd_pkg::rsp_t owed[$];
    int unsigned    mismatches;
    int unsigned    checked;

    function new();
      min_yr = 1500;
      cur_yr = 2021;
      mismatches = 0;
      checked = 0;
    endfunction

    static function bit is_leap(int unsigned y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    // Length of a month with the leap rule applied. Codes that name no month
    // give zero.
    static function int unsigned month_days(int unsigned y, int unsigned m);
      int unsigned len;
      case (m)
        1, 3, 5, 7, 8, 10, 12: len = 31;
        4, 6, 9, 11:           len = 30;
        2:                     len = is_leap(y) ? 29 : 28;
        default:               len = 0;
      endcase
      return len;
    endfunction

    // The year is checked first, then the month, then the day. The upper edge
    // of the window is current year plus one and does not wrap at 14 bits.
    function dvdd_pkg::status_e date_status(int unsigned y, int unsigned m, int unsigned d);
      if (y < min_yr || y > cur_yr + 1) return dvdd_pkg::ST_YEAR;
      if (m < 1 || m > 12) return dvdd_pkg::ST_MON;
      if (d < 1 || d > month_days(y, m)) return dvdd_pkg::ST_DAY;
      return dvdd_pkg::ST_OK;
    endfunction

    // Rata die with a March-based year. Division truncates toward zero, so for
    // year zero in January or February (shifted year -1) the quotients add nothing.
    // Months 13 to 15 run through the formula unshifted.
    static function longint rata_die(int unsigned y, int unsigned m, int unsigned d);
      longint ty;
      longint tm;
      ty = y;
      tm = m;
      if (tm < 3) begin
        ty = ty - 1;
        tm = tm + 12;
      end
      return 365 * ty + ty / 4 - ty / 100 + ty / 400 + (153 * tm - 457) / 5
             + longint'(d) - 306;
    endfunction

    function void note_request(dvdd_pkg::req_t r);
      dvdd_pkg::rsp_t e;
      longint         diff;
      diff = rata_die(r.year_a, r.month_a, r.day_a) - rata_die(r.year_b, r.month_b, r.day_b);
      e.status_a       = date_status(r.year_a, r.month_a, r.day_a);
      e.status_b       = date_status(r.year_b, r.month_b, r.day_b);
      e.day_difference = diff[23:0];
      owed.push_back(e);
    endfunction

    function void flag(string what, dvdd_pkg::rsp_t e, dvdd_pkg::rsp_t got);
      mismatches++;
      if (mismatches <= 10)
        $display("MISMATCH %s: expected st_a=%0d st_b=%0d diff=%0d, got st_a=%0d st_b=%0d diff=%0d",
                 what, e.status_a, e.status_b, e.day_difference,
                 got.status_a, got.status_b, got.day_difference);
    endfunction

    function void check_result(dvdd_pkg::rsp_t got);
      dvdd_pkg::rsp_t e;
      checked++;
      if (owed.size() == 0) begin
        e = '0;
        flag("result with nothing owed", e, got);
        return;
      end
      e = owed.pop_front();
      if (got.status_a !== e.status_a) flag("status_a", e, got);
      if (got.status_b !== e.status_b) flag("status_b", e, got);
      if (got.day_difference !== e.day_difference) flag("day_difference", e, got);
    endfunction
  endclass

  logic           clk_i = 1'b0;
  logic           rst_ni = 1'b0;
  logic           start = 1'b0;
  logic           busy;
  dvdd_pkg::req_t req_i = '0;
  logic           done_o;
  dvdd_pkg::rsp_t rsp_o;
  logic           psel = 1'b0;
  logic           penable = 1'b0;
  logic           pwrite = 1'b0;
  logic [2:0]     paddr = '0;
  logic [31:0]    pwdata = '0;
  logic [31:0]    prdata;
  logic           pready;

  day_diff_ledger ledger = new();
  int unsigned    cycles = 0;
  int unsigned    accepted = 0;
  int unsigned    reg_writes = 0;
  // While this is nonzero the sender issues back-to-back requests.
  int unsigned    burst_left = 0;

  date_validate_day_difference u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .done_o (done_o),
    .rsp_o  (rsp_o),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // The monitor samples at the rising edge. Every bench drive is nonblocking,
  // so these reads see the values that were in place before the edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        ledger.note_request(req_i);
        accepted++;
      end
      if (done_o) ledger.check_result(rsp_o);
    end
  end

  // Watchdog for the whole run.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still owed", cycles, ledger.owed.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Hands one request to the block. The sender first waits a random number of
  // cycles, except inside a burst. When there is no gap, start is not lowered
  // first, so it is never dropped and raised in the same step.
  task automatic send_request(dvdd_pkg::req_t r);
    int unsigned gap;
    if (burst_left > 0) begin
      gap = 0;
      burst_left--;
    end else begin
      gap = $urandom_range(12, 0);
      if ($urandom_range(7, 0) == 0) burst_left = $urandom_range(40, 10);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (!(start && !busy));
  endtask

  task automatic send_dates(int unsigned ya, int unsigned ma, int unsigned da,
                            int unsigned yb, int unsigned mb, int unsigned db);
    dvdd_pkg::req_t r;
    r.year_a  = ya[13:0];
    r.month_a = ma[3:0];
    r.day_a   = da[4:0];
    r.year_b  = yb[13:0];
    r.month_b = mb[3:0];
    r.day_b   = db[4:0];
    send_request(r);
  endtask

  // Lowers start and waits until every owed result has come back, then lets
  // the pipeline settle.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (ledger.owed.size() != 0) @(posedge clk_i);
    repeat (QUIET_CYCLES) @(posedge clk_i);
  endtask

  // One APB transfer: a setup cycle, then the access cycle that completes at
  // the edge where pready is high. On a read, prdata is checked at that edge.
  task automatic apb_transfer(logic wr, logic reg_sel, logic [13:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= {18'd0, val};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (wr) begin
      if (reg_sel == dvdd_pkg::REG_YEAR_FLOOR) ledger.min_yr = val;
      else ledger.cur_yr = val;
      reg_writes++;
    end else if (prdata !== {18'd0, val}) begin
      ledger.mismatches++;
      if (ledger.mismatches <= 10)
        $display("MISMATCH register readback at %0d: expected %0d, got %0d",
                 {reg_sel, 2'b00}, val, prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // The window is only moved while the pipeline is empty. Each write is read
  // back once.
  task automatic set_window(int unsigned lo, int unsigned hi);
    drain();
    apb_transfer(1'b1, dvdd_pkg::REG_YEAR_FLOOR, lo[13:0]);
    apb_transfer(1'b1, dvdd_pkg::REG_CURRENT_YEAR, hi[13:0]);
    apb_transfer(1'b0, dvdd_pkg::REG_YEAR_FLOOR, lo[13:0]);
    apb_transfer(1'b0, dvdd_pkg::REG_CURRENT_YEAR, hi[13:0]);
  endtask

  // Most dates are well formed and fall in the current window, so the month
  // and day checks are reached. Some sit on the window edges or one day past
  // the month end. The rest are raw noise over every field bit.
  task automatic random_date(output int unsigned y, output int unsigned m,
                             output int unsigned d);
    int unsigned kind;
    int unsigned lo;
    int unsigned hi;
    int unsigned len;
    kind = $urandom_range(9, 0);
    lo = ledger.min_yr;
    hi = (ledger.cur_yr + 1 > 16383) ? 16383 : ledger.cur_yr + 1;
    if (kind >= 7) begin
      y = $urandom_range(16383, 0);
      m = $urandom_range(15, 0);
      d = $urandom_range(31, 0);
    end else begin
      if (kind == 0) begin
        case ($urandom_range(3, 0))
          0:       y = lo;
          1:       y = hi;
          2:       y = (lo - 1) & 14'h3fff;
          default: y = (hi + 1) & 14'h3fff;
        endcase
      end else if (lo <= hi) begin
        y = $urandom_range(hi, lo);
      end else begin
        y = $urandom_range(16383, 0);
      end
      m = $urandom_range(12, 1);
      len = day_diff_ledger::month_days(y, m);
      if ($urandom_range(7, 0) == 0) d = (len + 1) & 5'h1f;
      else d = $urandom_range(len, 1);
    end
  endtask

  initial begin
    int unsigned ya;
    int unsigned ma;
    int unsigned da;
    int unsigned yb;
    int unsigned mb;
    int unsigned db;
    int unsigned lo;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed requests under the reset window, 1500 to 2022.
    send_dates(2021, 3, 1, 2021, 3, 1);
    send_dates(0, 0, 0, 16383, 15, 31);
    send_dates(16383, 15, 31, 0, 0, 0);
    send_dates(2000, 2, 29, 1900, 2, 29);     // century leap year against a plain century
    send_dates(2020, 2, 29, 2021, 2, 29);
    send_dates(1600, 2, 29, 1700, 2, 29);
    send_dates(2022, 12, 31, 2023, 1, 1);     // last year in the window, then just past it
    send_dates(1500, 1, 1, 1499, 12, 31);
    send_dates(2021, 0, 15, 2021, 13, 15);    // month zero borrows from the previous year
    send_dates(2021, 14, 1, 2021, 15, 31);
    send_dates(2021, 4, 31, 2021, 4, 0);
    send_dates(0, 1, 1, 0, 2, 28);            // year zero shifted to minus one
    send_dates(2000, 2, 30, 2000, 3, 1);
    send_dates(2012, 6, 30, 1970, 1, 1);
    send_dates(1999, 12, 31, 2000, 1, 1);

    // The widest window. A current year of 16383 must accept 16383 itself.
    set_window(0, 16383);
    send_dates(16383, 12, 31, 0, 3, 1);
    send_dates(16000, 2, 29, 16300, 2, 29);
    send_dates(0, 2, 29, 4, 2, 29);
    send_dates(16383, 2, 28, 16382, 1, 31);

    set_window(1500, 2021);

    for (int unsigned phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: ;                            // keep the reset window
        1: set_window(0, 16383);
        2: set_window(16383, 0);        // empty window: every year is rejected
        3: set_window(0, 0);
        4: set_window(16383, 16382);
        5: begin
          lo = $urandom_range(4000, 0);
          set_window(lo, $urandom_range(16382, lo));
        end
        default: set_window($urandom_range(16383, 0), $urandom_range(16382, 0));
      endcase
      for (int unsigned i = 0; i < ITEMS_PER_PHASE; i++) begin
        random_date(ya, ma, da);
        random_date(yb, mb, db);
        send_dates(ya, ma, da, yb, mb, db);
        // The sender sometimes holds off until the pipeline is empty.
        if ((phase == 0 && i == 100) || $urandom_range(199, 0) == 0) drain();
      end
    end

    drain();

    $display("covered %0d requests and %0d results over %0d register writes", accepted,
             ledger.checked, reg_writes);
    $display("window settings ran from empty to full; %0d mismatches, %0d results never came",
             ledger.mismatches, ledger.owed.size());
    if (ledger.mismatches == 0 && ledger.owed.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/dvdd_pkg.sv
rtl/core/dvdd_date_unit.sv
rtl/core/date_validate_day_difference.sv
bench/tb.sv
